/* rtl/rsvm_pkg.sv */
// shared types and constants for the register stack machine execute unit
package rsvm_pkg;

    // word widths and register file layout
    localparam int unsigned DATA_W = 32;
    localparam logic [3:0] NUM_REGS = 4'd9;
    localparam logic [3:0] FLAG_REG = 4'd8;

    // opcodes; the one code left over is unsupported
    typedef enum logic [3:0] {
        OP_PUSH  = 4'd0,
        OP_POP   = 4'd1,
        OP_PRINT = 4'd2,
        OP_HLT   = 4'd3,
        OP_MOVE  = 4'd4,
        OP_ADD   = 4'd5,
        OP_SUB   = 4'd6,
        OP_MUL   = 4'd7,
        OP_DIV   = 4'd8,
        OP_JMP   = 4'd9,
        OP_JMPC  = 4'd10,
        OP_GEQ   = 4'd11,
        OP_LEQ   = 4'd12,
        OP_GT    = 4'd13,
        OP_LT    = 4'd14
    } t_op;

    // fault codes reported with each result
    typedef enum logic [2:0] {
        FLT_NONE  = 3'd0,
        FLT_UNSUP = 3'd1,
        FLT_DIVZ  = 3'd2,
        FLT_OVF   = 3'd3,
        FLT_UNF   = 3'd4
    } t_fault;

    // instruction word
    typedef struct packed {
        logic [3:0]         cmd;
        logic               has_immediate;
        logic               has_register;
        logic [3:0]         reg_a;
        logic [3:0]         reg_b;
        logic signed [31:0] immediate;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [15:0]        next_pc;
        logic               print_valid;
        logic signed [31:0] print_value;
        logic               is_halted;
        logic [2:0]         fault;
    } t_out_word;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_EXEC,
        ST_DIV,
        ST_POP,
        ST_OUT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic latch;
        logic rd_a;
        logic rd_b;
        logic exec;
        logic div_wb;
        logic pop_wb;
        logic load_out;
    } t_ctl_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic needs_div;
        logic needs_pop;
        logic div_done;
    } t_dp_sts;

endpackage

/* rtl/rsvm_div.sv */
// iterative signed 32-bit divider, one quotient bit per cycle, truncating
module rsvm_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_dvs;
    logic        r_neg;
    logic [33:0] trial;
    logic [31:0] abs_dvd;
    logic [31:0] abs_dvs;

    // magnitudes; the most negative value maps onto itself as unsigned
    assign abs_dvd = i_dividend[31] ? (32'd0 - i_dividend) : i_dividend;
    assign abs_dvs = i_divisor[31] ? (32'd0 - i_divisor) : i_divisor;

    // restoring trial subtract
    assign trial = {1'b0, r_rem, r_quo[31]} - {2'b00, r_dvs};

    // control flags
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
        end else if (r_busy && (r_cnt == 5'd0)) begin
            n_busy = 1'b0;
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // shift and subtract datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= 32'd0;
            r_quo <= abs_dvd;
            r_dvs <= abs_dvs;
            r_neg <= i_dividend[31] ^ i_divisor[31];
            r_cnt <= 5'd31;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 5'd1;
            if (!trial[33]) begin
                r_rem <= trial[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= {r_rem[30:0], r_quo[31]};
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    // sign fix on the way out
    assign o_done     = r_done;
    assign o_quotient = r_neg ? (32'd0 - r_quo) : r_quo;

endmodule

/* rtl/rsvm_dp.sv */
// datapath: register file, stack memory, alu, program counter and result word
module rsvm_dp #(
    parameter int unsigned STACK_DEPTH = 4096,
    parameter int unsigned PC_BITS     = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rsvm_pkg::t_ctl_cmd  i_cmd,
    input  rsvm_pkg::t_in_word  i_in_word,
    output rsvm_pkg::t_dp_sts   o_sts,
    output rsvm_pkg::t_out_word o_out_word
);

    localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned AdrW = $clog2(STACK_DEPTH);
    localparam int unsigned PcW  = (PC_BITS > 16) ? PC_BITS : 16;

    // architectural state
    logic [31:0]         r_regs [rsvm_pkg::NUM_REGS];
    logic [31:0]         r_mem  [STACK_DEPTH];
    logic [31:0]         r_rdata;
    logic [CntW-1:0]     r_count;
    logic [PC_BITS-1:0]  r_pc;
    logic                r_halt;

    // per-instruction working registers
    rsvm_pkg::t_in_word  r_ins;
    logic [31:0]         r_opa;
    logic [31:0]         r_opb;
    logic [3:0]          r_dst;
    rsvm_pkg::t_out_word r_res;
    rsvm_pkg::t_out_word r_out;

    // combinational signals
    rsvm_pkg::t_op       op;
    logic [3:0]          rd_idx;
    logic [31:0]         rd_data;
    logic [3:0]          ar_dst;
    logic [31:0]         ar_a;
    logic [31:0]         ar_b;
    logic [31:0]         cmp_x;
    logic [31:0]         cmp_y;
    logic                cmp_t;
    logic [31:0]         jmp_off;
    logic [CntW-1:0]     cnt_m1;
    logic                full;
    logic                empty;
    logic                ex_we;
    logic [3:0]          ex_wa;
    logic [31:0]         ex_wd;
    logic [2:0]          ex_fault;
    logic                ex_take;
    logic                ex_print;
    logic                ex_halt;
    logic                mem_we;
    logic                mem_re;
    logic                needs_div;
    logic                needs_pop;
    logic [PC_BITS-1:0]  ex_next_pc;
    logic [PcW-1:0]      next_ext;
    logic                rf_we;
    logic [3:0]          rf_wa;
    logic [31:0]         rf_wd;
    logic                div_done;
    logic [31:0]         div_q;

    assign op = rsvm_pkg::t_op'(r_ins.cmd);

    // instruction latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_ins <= i_in_word;
        end
    end

    // single register file read port, out-of-range index reads zero
    assign rd_idx  = i_cmd.rd_a ? r_ins.reg_a : r_ins.reg_b;
    assign rd_data = (rd_idx < rsvm_pkg::NUM_REGS) ? r_regs[rd_idx] : 32'd0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_a) begin
            r_opa <= rd_data;
        end
        if (i_cmd.rd_b) begin
            r_opb <= rd_data;
        end
    end

    // operand routing
    assign ar_dst  = r_ins.has_register ? r_ins.reg_b : r_ins.reg_a;
    assign ar_a    = r_ins.has_register ? r_opb : r_opa;
    assign ar_b    = r_ins.has_register ? r_opa : r_ins.immediate;
    assign cmp_x   = r_ins.has_immediate ? r_ins.immediate : r_opa;
    assign cmp_y   = r_ins.has_immediate ? r_opa : r_opb;
    assign jmp_off = r_ins.has_immediate ? r_ins.immediate : r_opa;
    assign cnt_m1  = r_count - CntW'(1);
    assign full    = (r_count >= CntW'(STACK_DEPTH));
    assign empty   = (r_count == '0);

    // signed compare
    always_comb begin
        case (op)
            rsvm_pkg::OP_GEQ: cmp_t = ($signed(cmp_x) >= $signed(cmp_y));
            rsvm_pkg::OP_LEQ: cmp_t = ($signed(cmp_x) <= $signed(cmp_y));
            rsvm_pkg::OP_GT:  cmp_t = ($signed(cmp_x) > $signed(cmp_y));
            default:          cmp_t = ($signed(cmp_x) < $signed(cmp_y));
        endcase
    end

    // instruction execute
    always_comb begin
        ex_we     = 1'b0;
        ex_wa     = ar_dst;
        ex_wd     = 32'd0;
        ex_fault  = rsvm_pkg::FLT_NONE;
        ex_take   = 1'b0;
        ex_print  = 1'b0;
        ex_halt   = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        needs_div = 1'b0;
        needs_pop = 1'b0;
        if (!r_halt) begin
            case (op)
                rsvm_pkg::OP_PUSH: begin
                    if (full) begin
                        ex_fault = rsvm_pkg::FLT_OVF;
                    end else begin
                        mem_we = 1'b1;
                    end
                end
                rsvm_pkg::OP_POP: begin
                    if (empty) begin
                        ex_fault = rsvm_pkg::FLT_UNF;
                    end else begin
                        mem_re    = 1'b1;
                        needs_pop = 1'b1;
                    end
                end
                rsvm_pkg::OP_PRINT: ex_print = 1'b1;
                rsvm_pkg::OP_HLT:   ex_halt  = 1'b1;
                rsvm_pkg::OP_MOVE: begin
                    ex_we = 1'b1;
                    if (r_ins.has_register) begin
                        ex_wa = r_ins.reg_b;
                        ex_wd = r_opa;
                    end else begin
                        ex_wa = r_ins.reg_a;
                        ex_wd = r_ins.immediate;
                    end
                end
                rsvm_pkg::OP_ADD: begin
                    ex_we = 1'b1;
                    ex_wd = ar_a + ar_b;
                end
                rsvm_pkg::OP_SUB: begin
                    ex_we = 1'b1;
                    ex_wd = ar_a - ar_b;
                end
                rsvm_pkg::OP_MUL: begin
                    ex_we = 1'b1;
                    ex_wd = ar_a * ar_b;
                end
                rsvm_pkg::OP_DIV: begin
                    if (ar_b == 32'd0) begin
                        ex_fault = rsvm_pkg::FLT_DIVZ;
                    end else begin
                        needs_div = 1'b1;
                    end
                end
                rsvm_pkg::OP_JMP:  ex_take = 1'b1;
                rsvm_pkg::OP_JMPC: ex_take = (r_regs[rsvm_pkg::FLAG_REG] == 32'd1);
                rsvm_pkg::OP_GEQ, rsvm_pkg::OP_LEQ, rsvm_pkg::OP_GT, rsvm_pkg::OP_LT: begin
                    ex_we = 1'b1;
                    ex_wa = rsvm_pkg::FLAG_REG;
                    ex_wd = {31'd0, cmp_t};
                end
                default: ex_fault = rsvm_pkg::FLT_UNSUP;
            endcase
        end
    end

    // next program counter; halted or faulting instructions hold it
    always_comb begin
        if (r_halt || (ex_fault != rsvm_pkg::FLT_NONE)) begin
            ex_next_pc = r_pc;
        end else if (ex_take) begin
            ex_next_pc = r_pc + jmp_off[PC_BITS-1:0];
        end else begin
            ex_next_pc = r_pc + PC_BITS'(1);
        end
    end

    assign next_ext = PcW'(ex_next_pc);

    // machine state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= '0;
            r_halt  <= 1'b0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_pc   <= ex_next_pc;
            r_halt <= r_halt | ex_halt;
            if (mem_we) begin
                r_count <= r_count + CntW'(1);
            end else if (mem_re) begin
                r_count <= cnt_m1;
            end
        end
    end

    // stack memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && mem_we) begin
            r_mem[r_count[AdrW-1:0]] <= r_ins.has_immediate ? r_ins.immediate : r_opa;
        end
        if (i_cmd.exec && mem_re) begin
            r_rdata <= r_mem[cnt_m1[AdrW-1:0]];
        end
    end

    // divider
    rsvm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.exec & needs_div),
        .i_dividend (ar_a),
        .i_divisor  (ar_b),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // register file write port
    always_comb begin
        rf_we = 1'b0;
        rf_wa = r_dst;
        rf_wd = div_q;
        if (i_cmd.exec) begin
            rf_we = ex_we;
            rf_wa = ex_wa;
            rf_wd = ex_wd;
        end else if (i_cmd.div_wb) begin
            rf_we = 1'b1;
        end else if (i_cmd.pop_wb) begin
            rf_we = 1'b1;
            rf_wd = r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < int'(rsvm_pkg::NUM_REGS); i++) begin
                r_regs[i] <= 32'd0;
            end
        end else if (rf_we && (rf_wa < rsvm_pkg::NUM_REGS)) begin
            r_regs[rf_wa] <= rf_wd;
        end
    end

    // result capture and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_dst               <= (op == rsvm_pkg::OP_POP) ? r_ins.reg_a : ar_dst;
            r_res.next_pc       <= next_ext[15:0];
            r_res.print_valid   <= ex_print;
            r_res.print_value   <= ex_print ? r_opa : 32'd0;
            r_res.is_halted     <= r_halt | ex_halt;
            r_res.fault         <= ex_fault;
        end
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    assign o_sts.needs_div = needs_div;
    assign o_sts.needs_pop = needs_pop;
    assign o_sts.div_done  = div_done;
    assign o_out_word      = r_out;

endmodule

/* rtl/rsvm_ctrl.sv */
// controller: instruction sequencing state machine and handshakes
module rsvm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  rsvm_pkg::t_dp_sts  i_sts,
    output rsvm_pkg::t_ctl_cmd o_cmd
);

    rsvm_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rsvm_pkg::ST_IDLE: if (i_in_valid) n_state = rsvm_pkg::ST_RD_A;
            rsvm_pkg::ST_RD_A: n_state = rsvm_pkg::ST_RD_B;
            rsvm_pkg::ST_RD_B: n_state = rsvm_pkg::ST_EXEC;
            rsvm_pkg::ST_EXEC: begin
                if (i_sts.needs_div) begin
                    n_state = rsvm_pkg::ST_DIV;
                end else if (i_sts.needs_pop) begin
                    n_state = rsvm_pkg::ST_POP;
                end else begin
                    n_state = rsvm_pkg::ST_OUT;
                end
            end
            rsvm_pkg::ST_DIV: if (i_sts.div_done) n_state = rsvm_pkg::ST_OUT;
            rsvm_pkg::ST_POP: n_state = rsvm_pkg::ST_OUT;
            rsvm_pkg::ST_OUT: if (out_free) n_state = rsvm_pkg::ST_IDLE;
            default: n_state = rsvm_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_cmd = '0;
        case (r_state)
            rsvm_pkg::ST_IDLE: o_cmd.latch    = i_in_valid;
            rsvm_pkg::ST_RD_A: o_cmd.rd_a     = 1'b1;
            rsvm_pkg::ST_RD_B: o_cmd.rd_b     = 1'b1;
            rsvm_pkg::ST_EXEC: o_cmd.exec     = 1'b1;
            rsvm_pkg::ST_DIV:  o_cmd.div_wb   = i_sts.div_done;
            rsvm_pkg::ST_POP:  o_cmd.pop_wb   = 1'b1;
            rsvm_pkg::ST_OUT:  o_cmd.load_out = out_free;
            default: o_cmd = '0;
        endcase
    end

    // output word valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rsvm_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == rsvm_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* rtl/register_stack_vm_execute.sv */
// top level of the register stack machine execute unit
// Executes one decoded instruction word at a time against nine 32-bit registers (register 8
// is the compare flag), a STACK_DEPTH-word stack and a PC_BITS program counter. An accepted
// word goes through accept, two register file reads through the single read port, execute and
// result hand-off; pop adds a write-back state for the registered stack memory read, and div
// waits on the signed divider, which retires one quotient bit per cycle. The result word sits
// in an output register, so the next instruction word is taken while the previous result still
// waits; a new result is loaded only once that register is free. Faults (unsupported opcode,
// divide by zero, stack overflow, stack underflow) leave all state unchanged, and after a halt
// every further word returns the held pc with is_halted set.
module register_stack_vm_execute #(
    parameter int unsigned STACK_DEPTH = 4096,
    parameter int unsigned PC_BITS     = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rsvm_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rsvm_pkg::t_out_word o_out_word
);

    rsvm_pkg::t_ctl_cmd cmd;
    rsvm_pkg::t_dp_sts  sts;

    // sequencing
    rsvm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // machine state and execution
    rsvm_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .PC_BITS     (PC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_word  (i_in_word),
        .o_sts      (sts),
        .o_out_word (o_out_word)
    );

    // one word in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second word accepted while one is in flight");

    // a print never comes with a fault
    a_print_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.print_valid) |-> (o_out_word.fault == rsvm_pkg::FLT_NONE))
        else $error("print reported together with a fault");

    // a halted machine does not print
    a_halt_no_print: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.is_halted) |-> !o_out_word.print_valid)
        else $error("print reported while halted");

    // the result word holds while it waits
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_word)))
        else $error("result word changed while stalled");

endmodule
